[hw/rtl/recency_ordered_window_stack_core_assert.svh]
// Assertion macros used by the checker module of the window stack core.
`ifndef RECENCY_ORDERED_WINDOW_STACK_CORE_ASSERT_SVH
`define RECENCY_ORDERED_WINDOW_STACK_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ROWS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ROWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/rows_pkg.sv]
// Types, codes and default sizes of the recency ordered window stack.
package rows_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int ID_BITS_DEF  = 16;

    localparam logic [1:0] ACT_OPEN   = 2'd0;
    localparam logic [1:0] ACT_CLOSE  = 2'd1;
    localparam logic [1:0] ACT_SWITCH = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_INVALID   = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] window_id;
    } t_in_item;

    typedef struct packed {
        logic [15:0] front_id;
        logic        list_empty;
        logic [1:0]  status;
    } t_out_item;

endpackage

[hw/rtl/rows_ram.sv]
// Generic simple dual port RAM with one write port and a registered read port.
module rows_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/recency_ordered_window_stack_core.sv]
// Recency ordered window stack: a move-to-front list of window ids held in one RAM.
//
// The block keeps a most-recent-first list of up to CAPACITY window ids. Each input
// transaction carries an action (open, close, switch) and a window id, and every
// input transaction produces exactly one output transaction that reports the id now
// at the front of the list, an empty flag and a status. Open pushes the id to the
// front (duplicates are allowed) and reports full when no slot is left. Close removes
// the frontmost matching entry or reports not found. Switch moves the frontmost match
// to the front, or pushes a missing id and reports not found, or reports full when a
// missing id finds no room. An unrecognized action leaves the list alone and reports
// invalid. The list lives in a single RAM with one write port and one registered read
// port, stored oldest first, so the front is the highest occupied address and a push
// is a single write. Open and unrecognized actions go from acceptance straight to the
// response state, which moves the result into the output register once that register
// is free. Close and switch search from the front, one RAM read per cycle, and on a hit
// shift the entries above the hit down by one, again one read and one write per cycle.
// The longest transaction is a close that hits the oldest entry of a full list, which
// searches every entry and shifts all the others. The single RAM read port makes the
// search and the shift handle one entry at a time. The block works on one transaction
// at a time and is ready for the next one in the cycle after a result moves into the
// output register; a finished result sits in the output register while the next
// transaction is accepted and processed, and a result waits in the core until that
// register is free. Only the low ID_BITS bits of a window id are kept and compared.
// The RAM needs no clearing after reset, since only occupied entries are ever read.
module recency_ordered_window_stack_core #(
    parameter int CAPACITY = rows_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = rows_pkg::ID_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rows_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rows_pkg::t_out_item o_out_item
);

    import rows_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_FRONT,
        S_RESP
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic [ID_BITS-1:0] r_front;
    logic [1:0]        r_act;
    logic [ID_BITS-1:0] r_id;
    logic [CW-1:0]     r_left;
    logic [AW-1:0]     r_idx;
    logic              r_chk_vld;
    logic [AW-1:0]     r_chk_idx;
    logic [CW-1:0]     r_sh_rd;
    logic              r_wv;
    logic [AW-1:0]     r_wa;
    logic [1:0]        r_status;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic                 w_in_acc;
    logic                 w_out_free;
    logic [ID_BITS+15:0]  w_id_ext;
    logic [ID_BITS-1:0]   w_in_id;
    logic [ID_BITS+15:0]  w_front_ext;
    logic                 w_full;
    logic [CW-1:0]        w_cnt_m1;
    logic [CW-1:0]        w_cnt_m2;
    logic [CW-1:0]        w_sh_m1;
    logic                 w_match;
    logic                 w_search_issue;
    logic                 w_search_miss;
    logic                 w_sh_issue;
    logic                 w_sh_done;

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [ID_BITS-1:0]   w_wdata;
    logic                 w_re;
    logic [AW-1:0]        w_raddr;
    logic [ID_BITS-1:0]   w_rdata;

    rows_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (CAPACITY)
    ) u_rows_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Handshake and bookkeeping terms.
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Keep only the low ID_BITS bits of the incoming id, and widen or cut the stored
    // front id back to the sixteen bit result field.
    assign w_id_ext    = {{ID_BITS{1'b0}}, i_in_item.window_id};
    assign w_in_id     = w_id_ext[ID_BITS-1:0];
    assign w_front_ext = {16'b0, r_front};

    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_cnt_m1 = r_count - CW'(1);
    assign w_cnt_m2 = r_count - CW'(2);
    assign w_sh_m1  = r_sh_rd - CW'(1);

    // The search issues one read per cycle from the front downward and compares the
    // returned entry in the following cycle; a hit stops further issue.
    assign w_match        = r_chk_vld && (w_rdata == r_id);
    assign w_search_issue = (r_left != '0) && !w_match;
    assign w_search_miss  = (r_left == '0) && !w_match;

    // The shift reads the entry above each slot and writes it one slot lower in the
    // following cycle, from the hit up to the front.
    assign w_sh_issue = (r_sh_rd < r_count);
    assign w_sh_done  = !w_sh_issue && !r_wv;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_count[AW-1:0];
        w_wdata = r_id;
        w_re    = 1'b0;
        w_raddr = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_in_item.action == ACT_OPEN) && !w_full) begin
                    w_we    = 1'b1;
                    w_wdata = w_in_id;
                end
            end
            S_SEARCH: begin
                w_re = w_search_issue;
                if (w_search_miss && (r_act == ACT_SWITCH) && !w_full) begin
                    w_we = 1'b1;
                end
            end
            S_SHIFT: begin
                w_re    = w_sh_issue;
                w_raddr = r_sh_rd[AW-1:0];
                if (r_wv) begin
                    w_we    = 1'b1;
                    w_waddr = r_wa;
                    w_wdata = w_rdata;
                end
                if (w_sh_done) begin
                    if (r_act == ACT_SWITCH) begin
                        // The removed entry reappears at the front.
                        w_we    = 1'b1;
                        w_waddr = w_cnt_m1[AW-1:0];
                    end else if (w_cnt_m1 != '0) begin
                        // Fetch the new front after a close.
                        w_re    = 1'b1;
                        w_raddr = w_cnt_m2[AW-1:0];
                    end
                end
            end
            S_FRONT: begin
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_front     <= '0;
            r_chk_vld   <= 1'b0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // In the response state the output register is refilled instead.
            if (r_out_valid && i_out_ready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_act     <= i_in_item.action;
                        r_id      <= w_in_id;
                        r_chk_vld <= 1'b0;
                        r_wv      <= 1'b0;
                        unique case (i_in_item.action) inside
                            ACT_OPEN: begin
                                if (w_full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_count  <= r_count + CW'(1);
                                    r_front  <= w_in_id;
                                    r_status <= ST_OK;
                                end
                                r_state <= S_RESP;
                            end
                            ACT_CLOSE, ACT_SWITCH: begin
                                // An empty list falls straight through to a miss.
                                r_left  <= r_count;
                                r_idx   <= w_cnt_m1[AW-1:0];
                                r_state <= S_SEARCH;
                            end
                            default: begin
                                r_status <= ST_INVALID;
                                r_state  <= S_RESP;
                            end
                        endcase
                    end
                end
                S_SEARCH: begin
                    r_chk_vld <= w_search_issue;
                    r_chk_idx <= r_idx;
                    if (w_search_issue) begin
                        r_idx  <= r_idx - AW'(1);
                        r_left <= r_left - CW'(1);
                    end
                    if (w_match) begin
                        r_sh_rd <= CW'(r_chk_idx) + CW'(1);
                        r_wv    <= 1'b0;
                        r_state <= S_SHIFT;
                    end else if (w_search_miss) begin
                        if (r_act == ACT_CLOSE) begin
                            r_status <= ST_NOT_FOUND;
                        end else if (w_full) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_count  <= r_count + CW'(1);
                            r_front  <= r_id;
                            r_status <= ST_NOT_FOUND;
                        end
                        r_state <= S_RESP;
                    end
                end
                S_SHIFT: begin
                    r_wv <= w_sh_issue;
                    r_wa <= w_sh_m1[AW-1:0];
                    if (w_sh_issue) begin
                        r_sh_rd <= r_sh_rd + CW'(1);
                    end
                    if (w_sh_done) begin
                        r_status <= ST_OK;
                        if (r_act == ACT_SWITCH) begin
                            r_front <= r_id;
                            r_state <= S_RESP;
                        end else begin
                            r_count <= w_cnt_m1;
                            if (w_cnt_m1 == '0) begin
                                r_front <= '0;
                                r_state <= S_RESP;
                            end else begin
                                r_state <= S_FRONT;
                            end
                        end
                    end
                end
                S_FRONT: begin
                    r_front <= w_rdata;
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (w_out_free) begin
                        r_out_valid         <= 1'b1;
                        r_out_item.front_id   <= w_front_ext[15:0];
                        r_out_item.list_empty <= (r_count == '0);
                        r_out_item.status     <= r_status;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[hw/rtl/rows_checker.sv]
// Port level checker for the window stack core and its bind to the top level.
`include "recency_ordered_window_stack_core_assert.svh"

module rows_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input rows_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input rows_pkg::t_out_item o_out_item
);

    import rows_pkg::*;

    logic       w_in_acc;
    logic       w_out_acc;
    logic [1:0] r_outstanding;
    logic [1:0] n_outstanding;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    // Transactions accepted at the input whose result has not yet been taken.
    always_comb begin
        n_outstanding = r_outstanding;
        if (w_in_acc && !w_out_acc) begin
            n_outstanding = r_outstanding + 2'd1;
        end else if (!w_in_acc && w_out_acc) begin
            n_outstanding = r_outstanding - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= n_outstanding;
        end
    end

    `ROWS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item), "stalled result changed or dropped")
    `ROWS_ASSERT_SAME(a_empty_front, i_clk, i_rst_n, o_out_valid && o_out_item.list_empty, o_out_item.front_id == '0, "empty list reports a nonzero front id")
    `ROWS_ASSERT_SAME(a_full_not_empty, i_clk, i_rst_n, o_out_valid && (o_out_item.status == ST_FULL), !o_out_item.list_empty, "full status on an empty list")
    `ROWS_ASSERT_SAME(a_no_spurious_out, i_clk, i_rst_n, o_out_valid, r_outstanding != 2'd0, "result without an accepted transaction")
    `ROWS_ASSERT_SAME(a_one_in_flight, i_clk, i_rst_n, w_in_acc, r_outstanding <= 2'd1, "transaction accepted while two are pending")

endmodule

bind recency_ordered_window_stack_core rows_checker u_rows_checker (.*);

[dv/recency_ordered_window_stack_core_tb.sv]
// Self-checking testbench of the recency ordered window stack core.
module recency_ordered_window_stack_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rows_pkg::*;

    localparam int CAPACITY = CAPACITY_DEF;
    localparam int ID_BITS  = ID_BITS_DEF;
    localparam logic [15:0] ID_MASK = 16'(((64'd1) << ID_BITS) - 1);

    // The package names no code for an unrecognized action, so it is named here.
    localparam logic [1:0] ACT_UNKNOWN = 2'd3;

    // Worst case per transaction is a full search plus a full shift plus overhead.
    localparam int SETTLE_CYCLES = 2 * CAPACITY + 10;
    localparam int HOLD_CYCLES   = 400;

    logic      i_clk     = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    t_in_item  cmd_item  = '0;
    logic      cmd_ready;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    t_out_item rsp_item;

    // Idle percentages of each side, and the long receiver hold-off.
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    logic      hold_req      = 1'b0;
    int        hold_left     = 0;
    int        error_count   = 0;

    // Predicted list contents, front at index 0, and the results still owed.
    logic [15:0] window_list[$];
    t_out_item   expected_results[$];

    // Window ids drawn often, so that closes and switches find matches.
    logic [15:0] id_pool[8];

    recency_ordered_window_stack_core #(
        .CAPACITY(CAPACITY),
        .ID_BITS (ID_BITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (cmd_valid),
        .o_in_ready (cmd_ready),
        .i_in_item  (cmd_item),
        .o_out_valid(rsp_valid),
        .i_out_ready(rsp_ready),
        .o_out_item (rsp_item)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    // Applies one command to the predicted list and returns the result it must give.
    function automatic t_out_item apply_window_cmd(t_in_item cmd);
        t_out_item   res;
        logic [15:0] id;
        int          hit;
        id         = cmd.window_id & ID_MASK;
        hit        = -1;
        res.status = ST_OK;
        for (int i = 0; i < window_list.size(); i++) begin
            if (hit < 0 && window_list[i] == id) begin
                hit = i;
            end
        end
        case (cmd.action)
            ACT_OPEN: begin
                if (window_list.size() >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    window_list.push_front(id);
                end
            end
            ACT_CLOSE: begin
                if (hit < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    window_list.delete(hit);
                end
            end
            ACT_SWITCH: begin
                if (hit >= 0) begin
                    window_list.delete(hit);
                    window_list.push_front(id);
                end else if (window_list.size() < CAPACITY) begin
                    window_list.push_front(id);
                    res.status = ST_NOT_FOUND;
                end else begin
                    // A full list wins over a missing id.
                    res.status = ST_FULL;
                end
            end
            default: begin
                res.status = ST_INVALID;
            end
        endcase
        res.list_empty = (window_list.size() == 0);
        res.front_id   = res.list_empty ? 16'h0000 : window_list[0];
        return res;
    endfunction

    // Receiver: random backpressure, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            rsp_ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_req) begin
            rsp_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every accepted result is compared field by field with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (rst_n && rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result front_id=%h empty=%b status=%0d",
                         $time, rsp_item.front_id, rsp_item.list_empty, rsp_item.status);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (rsp_item.front_id !== want.front_id) begin
                    $display("%0t: front_id expected %h actual %h",
                             $time, want.front_id, rsp_item.front_id);
                    error_count++;
                end
                if (rsp_item.list_empty !== want.list_empty) begin
                    $display("%0t: list_empty expected %b actual %b",
                             $time, want.list_empty, rsp_item.list_empty);
                    error_count++;
                end
                if (rsp_item.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp_item.status);
                    error_count++;
                end
            end
        end
    end

    // Offers one command, holds it until the core takes it, then records the prediction.
    task automatic send_cmd(input logic [1:0] action, input logic [15:0] id);
        t_in_item cmd;
        cmd.action    = action;
        cmd.window_id = id;
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= cmd;
        do begin
            @(posedge i_clk);
        end while (!cmd_ready);
        expected_results.push_back(apply_window_cmd(cmd));
    endtask

    // Stops offering, waits for every owed result, then lets the core settle.
    task automatic wait_for_idle();
        cmd_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic refresh_id_pool();
        foreach (id_pool[i]) begin
            id_pool[i] = 16'($urandom);
        end
    endtask

    // Mostly ids already in the list or from a small pool, sometimes any id at all.
    function automatic logic [15:0] pick_window_id();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50 && window_list.size() != 0) begin
            return window_list[$urandom_range(window_list.size() - 1)];
        end else if (roll < 85) begin
            return id_pool[$urandom_range(7)];
        end
        return 16'($urandom);
    endfunction

    // Alternates stretches that fill the list with stretches that drain it,
    // so that both the full and the empty corner are visited again and again.
    task automatic run_random_traffic(input int count);
        logic [1:0] action;
        int         roll;
        logic       filling;
        filling = 1'b1;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                refresh_id_pool();
                filling = ~filling;
            end
            roll = $urandom_range(99);
            if (filling) begin
                action = (roll < 45) ? ACT_OPEN : (roll < 75) ? ACT_SWITCH :
                         (roll < 90) ? ACT_CLOSE : ACT_UNKNOWN;
            end else begin
                action = (roll < 15) ? ACT_OPEN : (roll < 35) ? ACT_SWITCH :
                         (roll < 90) ? ACT_CLOSE : ACT_UNKNOWN;
            end
            send_cmd(action, pick_window_id());
        end
    endtask

    // Empty list, unknown action, duplicates, a full list and the switch corners.
    task automatic test_directed_corners();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_cmd(ACT_CLOSE,   16'h0005);
        send_cmd(ACT_UNKNOWN, 16'hFFFF);
        send_cmd(ACT_SWITCH,  16'h1234);
        send_cmd(ACT_OPEN,    16'h0000);
        send_cmd(ACT_OPEN,    16'hFFFF);
        send_cmd(ACT_OPEN,    16'hFFFF);
        for (int i = 0; i < CAPACITY - 4; i++) begin
            send_cmd(ACT_OPEN, 16'h8001 + 16'(i) * 16'h0111);
        end
        send_cmd(ACT_OPEN,    16'h7777);
        send_cmd(ACT_SWITCH,  16'h7777);
        // The oldest entry moves to the front even though the list is full.
        send_cmd(ACT_SWITCH,  16'h1234);
        send_cmd(ACT_UNKNOWN, 16'h0000);
        send_cmd(ACT_CLOSE,   16'hFFFF);
        send_cmd(ACT_CLOSE,   16'h7777);
        wait_for_idle();
    endtask

    task automatic test_random_slow_receiver();
        send_idle_pct = 16;
        recv_idle_pct = 71;
        run_random_traffic(600);
        wait_for_idle();
    endtask

    task automatic test_random_slow_sender();
        send_idle_pct = 71;
        recv_idle_pct = 16;
        run_random_traffic(600);
        wait_for_idle();
    endtask

    // The receiver stops for a long stretch while commands keep coming, so the
    // output register and the core both fill and the input stalls.
    task automatic test_output_hold_off();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cmd_valid <= 1'b0;
        hold_req  <= 1'b1;
        @(posedge i_clk);
        hold_req  <= 1'b0;
        run_random_traffic(40);
        wait_for_idle();
    endtask

    task automatic test_random_full_rate();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_traffic(640);
        wait_for_idle();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_corners();
        test_random_slow_receiver();
        test_random_slow_sender();
        test_output_hold_off();
        test_random_full_rate();
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/rows_pkg.sv
hw/rtl/rows_ram.sv
hw/rtl/recency_ordered_window_stack_core.sv
hw/rtl/rows_checker.sv
dv/recency_ordered_window_stack_core_tb.sv
